FILE: rtl/hsvtc_pkg.sv
// shared constants, register codes and control types for the hsv blob centroid block
package hsvtc_pkg;

    // fixed field widths
    localparam int CHAN_W     = 8;
    localparam int BOUND_W    = 9;
    localparam int AREA_W     = 23;
    localparam int SUM_W      = 34;
    localparam int CTR_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 23;

    // parameter defaults
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 2048;
    localparam int DEF_FRAC_BITS  = 4;

    localparam logic [AREA_W-1:0] AREA_LIMIT = {AREA_W{1'b1}};
    localparam logic [CTR_W-1:0]  CENTER_MAX = {CTR_W{1'b1}};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HUE_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VAL_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HUE_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAT_HIGH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VAL_HIGH = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_AREA = 3'd6;

    // register reset values
    localparam logic [CHAN_W-1:0]  RST_HUE_LOW  = 8'd0;
    localparam logic [CHAN_W-1:0]  RST_SAT_LOW  = 8'd146;
    localparam logic [CHAN_W-1:0]  RST_VAL_LOW  = 8'd40;
    localparam logic [BOUND_W-1:0] RST_HUE_HIGH = 9'd180;
    localparam logic [BOUND_W-1:0] RST_SAT_HIGH = 9'd256;
    localparam logic [BOUND_W-1:0] RST_VAL_HIGH = 9'd256;
    localparam logic [AREA_W-1:0]  RST_MIN_AREA = 23'd2000;

    // threshold window
    typedef struct packed {
        logic [CHAN_W-1:0]  hue_low;
        logic [CHAN_W-1:0]  sat_low;
        logic [CHAN_W-1:0]  val_low;
        logic [BOUND_W-1:0] hue_high;
        logic [BOUND_W-1:0] sat_high;
        logic [BOUND_W-1:0] val_high;
    } bounds_t;

    // controller commands to the datapath
    typedef struct packed {
        logic pix_en;
        logic div_load;
        logic div_step;
        logic out_load;
    } cmd_t;

endpackage

FILE: rtl/hsvtc_accum.sv
// pixel mask test, raster position counters and moment accumulators
module hsvtc_accum #(
    parameter int MAX_WIDTH  = hsvtc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hsvtc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  hsvtc_pkg::cmd_t                 cmd,
    input  hsvtc_pkg::bounds_t              bounds,
    input  logic [hsvtc_pkg::CHAN_W-1:0]    hue,
    input  logic [hsvtc_pkg::CHAN_W-1:0]    sat,
    input  logic [hsvtc_pkg::CHAN_W-1:0]    val,
    input  logic                            line_end,
    input  logic                            frame_end,
    output logic [hsvtc_pkg::AREA_W-1:0]    area_total,
    output logic [hsvtc_pkg::SUM_W-1:0]     sum_x_total,
    output logic [hsvtc_pkg::SUM_W-1:0]     sum_y_total
);
    import hsvtc_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam logic [63:0] CELLS = 64'(MAX_WIDTH) * 64'(MAX_HEIGHT);
    localparam logic [AREA_W-1:0] AREA_CAP =
        (CELLS < 64'(AREA_LIMIT)) ? AREA_W'(CELLS) : AREA_LIMIT;
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_HEIGHT - 1);

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [AREA_W-1:0] count_reg, count_next;
    logic [SUM_W-1:0]  sum_x_reg, sum_x_next;
    logic [SUM_W-1:0]  sum_y_reg, sum_y_next;
    logic              in_mask;

    // inclusive window on all three channels, count capped
    assign in_mask = ({1'b0, hue} >= {1'b0, bounds.hue_low}) && ({1'b0, hue} <= bounds.hue_high)
                  && ({1'b0, sat} >= {1'b0, bounds.sat_low}) && ({1'b0, sat} <= bounds.sat_high)
                  && ({1'b0, val} >= {1'b0, bounds.val_low}) && ({1'b0, val} <= bounds.val_high)
                  && (count_reg < AREA_CAP);

    // totals including the current pixel
    always_comb
    begin
        area_total  = count_reg;
        sum_x_total = sum_x_reg;
        sum_y_total = sum_y_reg;
        if (in_mask)
        begin
            area_total  = count_reg + 1'b1;
            sum_x_total = sum_x_reg + SUM_W'(col_reg);
            sum_y_total = sum_y_reg + SUM_W'(row_reg);
        end
    end

    // next state of counters and accumulators
    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        count_next = count_reg;
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        if (cmd.pix_en)
        begin
            if (frame_end)
            begin
                col_next   = '0;
                row_next   = '0;
                count_next = '0;
                sum_x_next = '0;
                sum_y_next = '0;
            end
            else
            begin
                count_next = area_total;
                sum_x_next = sum_x_total;
                sum_y_next = sum_y_total;
                if (line_end)
                begin
                    col_next = '0;
                    if (row_reg < ROW_LAST)
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else if (col_reg < COL_LAST)
                begin
                    col_next = col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            count_reg <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            count_reg <= count_next;
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
        end
    end

endmodule

FILE: rtl/hsvtc_div.sv
// two-lane restoring divider for the rounded, saturated centroid
module hsvtc_div #(
    parameter int FRAC_BITS = hsvtc_pkg::DEF_FRAC_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  hsvtc_pkg::cmd_t                 cmd,
    input  logic [hsvtc_pkg::AREA_W-1:0]    area_in,
    input  logic [hsvtc_pkg::SUM_W-1:0]     sum_x_in,
    input  logic [hsvtc_pkg::SUM_W-1:0]     sum_y_in,
    input  logic [hsvtc_pkg::AREA_W-1:0]    min_area,
    output logic [hsvtc_pkg::AREA_W-1:0]    res_area,
    output logic [hsvtc_pkg::CTR_W-1:0]     res_x,
    output logic [hsvtc_pkg::CTR_W-1:0]     res_y,
    output logic                            res_found
);
    import hsvtc_pkg::*;

    localparam int NUM_W = SUM_W + FRAC_BITS + 1;

    logic [AREA_W-1:0] area_reg;
    logic              found_reg;
    logic [NUM_W-1:0]  num_reg [2];
    logic [AREA_W-1:0] rem_reg [2];
    logic [CTR_W-1:0]  q_reg   [2];
    logic              ovf_reg [2];
    logic [AREA_W:0]   rem_sh  [2];
    logic              q_bit   [2];
    logic [AREA_W-1:0] rem_new [2];
    logic [SUM_W-1:0]  sum_in  [2];
    logic [CTR_W-1:0]  center  [2];

    assign sum_in[0] = sum_x_in;
    assign sum_in[1] = sum_y_in;

    // one quotient bit per lane per step
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            rem_sh[i]  = {rem_reg[i], num_reg[i][NUM_W-1]};
            q_bit[i]   = (rem_sh[i] >= {1'b0, area_reg});
            rem_new[i] = q_bit[i] ? AREA_W'(rem_sh[i] - {1'b0, area_reg})
                                  : AREA_W'(rem_sh[i]);
            center[i]  = !found_reg ? '0 : (ovf_reg[i] ? CENTER_MAX : q_reg[i]);
        end
    end

    // operand load and iteration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_reg  <= '0;
            found_reg <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                num_reg[i] <= '0;
                rem_reg[i] <= '0;
                q_reg[i]   <= '0;
                ovf_reg[i] <= 1'b0;
            end
        end
        else if (cmd.div_load)
        begin
            area_reg  <= area_in;
            found_reg <= (area_in > min_area);
            for (int i = 0; i < 2; i++)
            begin
                num_reg[i] <= (NUM_W'(sum_in[i]) << FRAC_BITS) + NUM_W'(area_in >> 1);
                rem_reg[i] <= '0;
                q_reg[i]   <= '0;
                ovf_reg[i] <= 1'b0;
            end
        end
        else if (cmd.div_step)
        begin
            for (int i = 0; i < 2; i++)
            begin
                num_reg[i] <= num_reg[i] << 1;
                rem_reg[i] <= rem_new[i];
                q_reg[i]   <= {q_reg[i][CTR_W-2:0], q_bit[i]};
                ovf_reg[i] <= ovf_reg[i] | q_reg[i][CTR_W-1];
            end
        end
    end

    assign res_area  = area_reg;
    assign res_x     = center[0];
    assign res_y     = center[1];
    assign res_found = found_reg;

endmodule

FILE: rtl/hsvtc_ctrl.sv
// controller: pixel acceptance, divide sequencing and result handoff
module hsvtc_ctrl #(
    parameter int FRAC_BITS = hsvtc_pkg::DEF_FRAC_BITS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    input  logic            frame_end,
    input  logic            m_tready,
    output logic            s_tready,
    output logic            m_tvalid,
    output hsvtc_pkg::cmd_t cmd
);
    import hsvtc_pkg::*;

    localparam int NUM_W  = SUM_W + FRAC_BITS + 1;
    localparam int STEP_W = $clog2(NUM_W);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NUM_W - 1);

    localparam logic [1:0] ST_ACC = 2'd0;
    localparam logic [1:0] ST_DIV = 2'd1;
    localparam logic [1:0] ST_OUT = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              m_valid_reg, m_valid_next;
    logic              pix_fire;
    logic              slot_free;

    assign s_tready  = (state_reg == ST_ACC);
    assign pix_fire  = s_tvalid && s_tready;
    assign slot_free = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;

    // state transitions and commands
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg && !m_tready;
        cmd          = '0;
        cmd.pix_en   = pix_fire;
        case (state_reg)
            ST_ACC:
            begin
                if (pix_fire && frame_end)
                begin
                    cmd.div_load = 1'b1;
                    step_next    = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == STEP_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
                step_next  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_ACC;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result never overwrites a word still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> slot_free)
        else $error("result loaded while output word pending");

    // step counter idles at zero outside the divide
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_DIV) |-> (step_reg == '0))
        else $error("step counter not cleared outside divide");

    // frame end starts the divide on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (pix_fire && frame_end) |=> (state_reg == ST_DIV && step_reg == '0))
        else $error("divide did not start after frame end");

    // a result word is raised only through the handoff state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("output word raised outside handoff");

endmodule

FILE: rtl/hsv_threshold_blob_centroid.sv
// top level of the hsv threshold blob centroid block
//
//  channel | direction | word                                   | accepted when
//  --------+-----------+----------------------------------------+--------------------------
//  s_*     | in        | hue/sat/val pixel, line end, frame end | s_tvalid & s_tready
//  m_*     | out       | area, centroid x/y, found              | m_tvalid & m_tready
//  cfg_*   | in        | register index and data                | cfg_valid & cfg_ready
//
// pixels are taken one per cycle while a frame streams in.
// the pixel carrying frame end starts a one-bit-per-cycle divide in both
// centroid lanes: SUM_W + FRAC_BITS + 1 steps (39 at the defaults), and the
// input is held off through the divide and the result handoff.
// the output word sits in its own register; a stalled output delays only
// the end of the next frame, not the pixels before it.
// reset clears all counters, sums and control state and loads the
// register defaults; no clearing pass is needed.
module hsv_threshold_blob_centroid #(
    parameter int MAX_WIDTH  = hsvtc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = hsvtc_pkg::DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = hsvtc_pkg::DEF_FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // pixel input
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,   // hue, sat, val
    input  logic                                s_tuser,   // line_end
    input  logic                                s_tlast,   // frame_end
    // result output
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [55:0]                         m_tdata,   // pixel_area, center_x, center_y, pad
    output logic                                m_tuser,   // found
    // register writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hsvtc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hsvtc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import hsvtc_pkg::*;

    cmd_t              cmd;
    bounds_t           bounds_reg;
    logic [AREA_W-1:0] min_area_reg;
    logic [AREA_W-1:0] area_total;
    logic [SUM_W-1:0]  sum_x_total;
    logic [SUM_W-1:0]  sum_y_total;
    logic [AREA_W-1:0] res_area;
    logic [CTR_W-1:0]  res_x;
    logic [CTR_W-1:0]  res_y;
    logic              res_found;
    logic [AREA_W-1:0] out_area_reg;
    logic [CTR_W-1:0]  out_x_reg;
    logic [CTR_W-1:0]  out_y_reg;
    logic              out_found_reg;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounds_reg.hue_low  <= RST_HUE_LOW;
            bounds_reg.sat_low  <= RST_SAT_LOW;
            bounds_reg.val_low  <= RST_VAL_LOW;
            bounds_reg.hue_high <= RST_HUE_HIGH;
            bounds_reg.sat_high <= RST_SAT_HIGH;
            bounds_reg.val_high <= RST_VAL_HIGH;
            min_area_reg        <= RST_MIN_AREA;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_HUE_LOW:  bounds_reg.hue_low  <= cfg_data[CHAN_W-1:0];
                REG_SAT_LOW:  bounds_reg.sat_low  <= cfg_data[CHAN_W-1:0];
                REG_VAL_LOW:  bounds_reg.val_low  <= cfg_data[CHAN_W-1:0];
                REG_HUE_HIGH: bounds_reg.hue_high <= cfg_data[BOUND_W-1:0];
                REG_SAT_HIGH: bounds_reg.sat_high <= cfg_data[BOUND_W-1:0];
                REG_VAL_HIGH: bounds_reg.val_high <= cfg_data[BOUND_W-1:0];
                REG_MIN_AREA: min_area_reg        <= cfg_data[AREA_W-1:0];
                default:      ;
            endcase
        end
    end

    hsvtc_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .frame_end (s_tlast),
        .m_tready  (m_tready),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .cmd       (cmd)
    );

    hsvtc_accum #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .bounds      (bounds_reg),
        .hue         (s_tdata[7:0]),
        .sat         (s_tdata[15:8]),
        .val         (s_tdata[23:16]),
        .line_end    (s_tuser),
        .frame_end   (s_tlast),
        .area_total  (area_total),
        .sum_x_total (sum_x_total),
        .sum_y_total (sum_y_total)
    );

    hsvtc_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .area_in   (area_total),
        .sum_x_in  (sum_x_total),
        .sum_y_in  (sum_y_total),
        .min_area  (min_area_reg),
        .res_area  (res_area),
        .res_x     (res_x),
        .res_y     (res_y),
        .res_found (res_found)
    );

    // output word register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_area_reg  <= res_area;
            out_x_reg     <= res_x;
            out_y_reg     <= res_y;
            out_found_reg <= res_found;
        end
    end

    assign m_tdata = {3'b000, out_y_reg, out_x_reg, out_area_reg};
    assign m_tuser = out_found_reg;

endmodule

FILE: tb/blob_centroid_check.sv
// checker: follows the pixel, result and register channels, predicts each blob result and compares
`timescale 1ns / 1ps
module blob_centroid_check (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [23:0]                      s_tdata,   // hue, sat, val
    input  logic                             s_tuser,   // line_end
    input  logic                             s_tlast,   // frame_end
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [55:0]                      m_tdata,   // pixel_area, center_x, center_y, pad
    input  logic                             m_tuser,   // found
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [hsvtc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hsvtc_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                               pending,
    output int                               fail_count
);
    import hsvtc_pkg::*;

    localparam int POS_W    = $clog2(DEF_MAX_WIDTH);
    localparam int COL_LAST = DEF_MAX_WIDTH - 1;
    localparam int ROW_LAST = DEF_MAX_HEIGHT - 1;
    localparam longint unsigned FULL_AREA = longint'(DEF_MAX_WIDTH) * DEF_MAX_HEIGHT;
    localparam longint unsigned AREA_CAP  = (FULL_AREA < AREA_LIMIT) ? FULL_AREA : AREA_LIMIT;

    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic [CTR_W-1:0]  cx;
        logic [CTR_W-1:0]  cy;
        logic              found;
    } blob_t;

    blob_t             blob_q[$];
    bounds_t           window;
    logic [AREA_W-1:0] min_area;
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  row;
    logic [AREA_W-1:0] mask_cnt;
    logic [SUM_W-1:0]  sum_x;
    logic [SUM_W-1:0]  sum_y;

    // rounded fixed-point mean, saturated to the output width
    function automatic logic [CTR_W-1:0] centroid_of(input logic [SUM_W-1:0] sum,
                                                     input logic [AREA_W-1:0] area);
        longint unsigned num;
        longint unsigned q;
        if (area == 0)
            return '0;
        num = sum;
        q = ((num << DEF_FRAC_BITS) + (area >> 1)) / area;
        if (q > CENTER_MAX)
            return CENTER_MAX;
        return q[CTR_W-1:0];
    endfunction

    function automatic bit in_band(input logic [CHAN_W-1:0] v, input logic [CHAN_W-1:0] lo,
                                   input logic [BOUND_W-1:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // predict on every accepted pixel, compare every accepted result word
    always @(posedge clk or negedge rst_n)
    begin
        blob_t             got;
        blob_t             want;
        logic [CHAN_W-1:0] hue;
        logic [CHAN_W-1:0] sat;
        logic [CHAN_W-1:0] val;
        bit                hit;
        bit                found;
        if (!rst_n)
        begin
            blob_q.delete();
            window.hue_low  = RST_HUE_LOW;
            window.sat_low  = RST_SAT_LOW;
            window.val_low  = RST_VAL_LOW;
            window.hue_high = RST_HUE_HIGH;
            window.sat_high = RST_SAT_HIGH;
            window.val_high = RST_VAL_HIGH;
            min_area = RST_MIN_AREA;
            col      = '0;
            row      = '0;
            mask_cnt = '0;
            sum_x    = '0;
            sum_y    = '0;
            pending <= 0;
        end
        else
        begin
            // result word against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[22:0], m_tdata[37:23], m_tdata[52:38], m_tuser};
                if (blob_q.size() == 0)
                    report_mismatch($sformatf("result word with nothing expected, area %0d",
                                              got.area));
                else
                begin
                    want = blob_q.pop_front();
                    if (got.area !== want.area)
                        report_mismatch($sformatf("pixel_area got %0d expected %0d",
                                                  got.area, want.area));
                    if (got.cx !== want.cx)
                        report_mismatch($sformatf("center_x got %0d expected %0d",
                                                  got.cx, want.cx));
                    if (got.cy !== want.cy)
                        report_mismatch($sformatf("center_y got %0d expected %0d",
                                                  got.cy, want.cy));
                    if (got.found !== want.found)
                        report_mismatch($sformatf("found got %0b expected %0b",
                                                  got.found, want.found));
                end
            end

            // register writes, unknown indexes are dropped
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_HUE_LOW:  window.hue_low  = cfg_data[CHAN_W-1:0];
                    REG_SAT_LOW:  window.sat_low  = cfg_data[CHAN_W-1:0];
                    REG_VAL_LOW:  window.val_low  = cfg_data[CHAN_W-1:0];
                    REG_HUE_HIGH: window.hue_high = cfg_data[BOUND_W-1:0];
                    REG_SAT_HIGH: window.sat_high = cfg_data[BOUND_W-1:0];
                    REG_VAL_HIGH: window.val_high = cfg_data[BOUND_W-1:0];
                    REG_MIN_AREA: min_area        = cfg_data[AREA_W-1:0];
                    default: ;
                endcase
            end

            // pixel word: accumulate, then close the frame or advance position
            if (s_tvalid && s_tready)
            begin
                hue = s_tdata[7:0];
                sat = s_tdata[15:8];
                val = s_tdata[23:16];
                hit = in_band(hue, window.hue_low, window.hue_high) &&
                      in_band(sat, window.sat_low, window.sat_high) &&
                      in_band(val, window.val_low, window.val_high) &&
                      (mask_cnt < AREA_CAP);
                if (hit)
                begin
                    mask_cnt = mask_cnt + 1'b1;
                    sum_x    = sum_x + col;
                    sum_y    = sum_y + row;
                end
                if (s_tlast)
                begin
                    found      = mask_cnt > min_area;
                    want.area  = mask_cnt;
                    want.cx    = found ? centroid_of(sum_x, mask_cnt) : '0;
                    want.cy    = found ? centroid_of(sum_y, mask_cnt) : '0;
                    want.found = found;
                    blob_q.push_back(want);
                    col      = '0;
                    row      = '0;
                    mask_cnt = '0;
                    sum_x    = '0;
                    sum_y    = '0;
                end
                else if (s_tuser)
                begin
                    col = '0;
                    if (row < ROW_LAST)
                        row = row + 1'b1;
                end
                else if (col < COL_LAST)
                    col = col + 1'b1;
            end

            pending <= blob_q.size();
        end
    end

endmodule

FILE: tb/hsv_threshold_blob_centroid_test.sv
// testbench top: clock, reset, pixel and register stimulus, result backpressure and verdict
`timescale 1ns / 1ps
module hsv_threshold_blob_centroid_test;
    import hsvtc_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 1400;
    localparam int PHASE_ITEMS  = 100;
    localparam int LONG_RUN     = 2060;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int AREA_TOP     = 4194304;
    localparam int BOUND_TOP    = 256;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata   = '0;   // hue, sat, val
    logic                  s_tuser   = 1'b0; // line_end
    logic                  s_tlast   = 1'b0; // frame_end
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [55:0]           m_tdata;          // pixel_area, center_x, center_y, pad
    logic                  m_tuser;          // found
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int pending;
    int fail_count;
    int send_idle   = 12;
    int recv_idle   = 54;
    int hold_req    = 0;
    int hold_done   = 0;
    int pixels_sent = 0;
    int cycles      = 0;
    int win_lo[3];
    int win_hi[3];

    hsv_threshold_blob_centroid dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    blob_centroid_check blob_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // runaway guard
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[hsv_threshold_blob_centroid] ERROR");
        $finish;
    end

    // result side: random stalls, or a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                hold_done++;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // one pixel word, with random idle cycles ahead of it
    task automatic send_pixel(input logic [7:0] hue, input logic [7:0] sat,
                              input logic [7:0] val, input logic line_end,
                              input logic frame_end);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {val, sat, hue};
        s_tuser  <= line_end;
        s_tlast  <= frame_end;
        do @(posedge clk); while (!s_tready);
        pixels_sent++;
    endtask

    // one register word; valid stays up for the next one
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        do @(posedge clk); while (!cfg_ready);
    endtask

    // full threshold window plus area floor
    task automatic write_window(input int hl, input int sl, input int vl, input int hh,
                                input int sh, input int vh, input int ma,
                                input bit poke_unused);
        put_reg(REG_HUE_LOW, hl);
        put_reg(REG_SAT_LOW, sl);
        put_reg(REG_VAL_LOW, vl);
        put_reg(REG_HUE_HIGH, hh);
        put_reg(REG_SAT_HIGH, sh);
        put_reg(REG_VAL_HIGH, vh);
        put_reg(REG_MIN_AREA, ma);
        if (poke_unused)
            put_reg(REG_UNUSED, 0);
        cfg_valid <= 1'b0;
        win_lo = '{hl, sl, vl};
        win_hi = '{hh, sh, vh};
    endtask

    // stop sending, wait for every result, then let the pipeline drain
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // channel value biased toward the window and its edges
    function automatic logic [7:0] pick_chan(input int lo, input int hi);
        int r;
        int v;
        r = $urandom_range(99);
        if (r < 30)
            v = $urandom_range(255);
        else if (r < 50)
        begin
            case ($urandom_range(3))
                0: v = lo;
                1: v = lo - 1;
                2: v = hi;
                default: v = hi + 1;
            endcase
        end
        else if (lo <= hi)
            v = $urandom_range((hi > 255) ? 255 : hi, lo);
        else
            v = $urandom_range(255);
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[7:0];
    endfunction

    // raster frame; ragged frames throw in stray line ends
    task automatic send_frame(input int w, input int h, input bit ragged);
        logic le;
        logic fe;
        for (int r = 0; r < h; r++)
        begin
            for (int c = 0; c < w; c++)
            begin
                fe = (r == h - 1) && (c == w - 1);
                le = (c == w - 1) || (ragged && ($urandom_range(9) == 0));
                if (fe)
                    le = 1'($urandom_range(1));
                send_pixel(pick_chan(win_lo[0], win_hi[0]), pick_chan(win_lo[1], win_hi[1]),
                           pick_chan(win_lo[2], win_hi[2]), le, fe);
            end
        end
    endtask

    // random window per channel, now and then inverted or wide open
    task automatic random_window();
        int lo[3];
        int hi[3];
        int k;
        int ma;
        for (int ch = 0; ch < 3; ch++)
        begin
            k = $urandom_range(9);
            if (k == 0)
            begin
                lo[ch] = $urandom_range(255);
                hi[ch] = $urandom_range(BOUND_TOP);
            end
            else if (k == 1)
            begin
                lo[ch] = 0;
                hi[ch] = BOUND_TOP;
            end
            else
            begin
                lo[ch] = $urandom_range(160);
                hi[ch] = $urandom_range(BOUND_TOP, lo[ch] + 40);
            end
        end
        case ($urandom_range(9))
            0: ma = 0;
            1: ma = AREA_TOP;
            2: ma = $urandom_range(AREA_TOP);
            default: ma = $urandom_range(30);
        endcase
        write_window(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], ma, 1'b0);
    endtask

    // stimulus and verdict
    initial
    begin
        int phase;
        int base;
        int phase_base;
        int progress;

        win_lo = '{RST_HUE_LOW, RST_SAT_LOW, RST_VAL_LOW};
        win_hi = '{RST_HUE_HIGH, RST_SAT_HIGH, RST_VAL_HIGH};
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // reset window: single-pixel frames, one with both marks, then band edges
        send_pixel(8'd0, 8'd255, 8'd255, 1'b1, 1'b1);
        send_pixel(8'd255, 8'd0, 8'd0, 1'b0, 1'b1);
        send_pixel(8'd180, 8'd146, 8'd40, 1'b0, 1'b0);
        send_pixel(8'd181, 8'd146, 8'd40, 1'b0, 1'b0);
        send_pixel(8'd180, 8'd145, 8'd40, 1'b1, 1'b0);
        send_pixel(8'd180, 8'd146, 8'd39, 1'b0, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd255, 1'b0, 1'b0);
        send_pixel(8'd90, 8'd200, 8'd200, 1'b1, 1'b1);
        settle();

        // open window, no area floor, stray index written too
        write_window(0, 0, 0, BOUND_TOP, BOUND_TOP, BOUND_TOP, 0, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b1);

        // row longer than the column range, then frame taller than the row range
        for (int i = 0; i < LONG_RUN; i++)
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), (i == LONG_RUN - 1), 1'b0);
        for (int i = 0; i < 3; i++)
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), (i == 2), (i == 2));
        for (int i = 0; i < LONG_RUN; i++)
            send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b1, (i == LONG_RUN - 1));
        settle();

        // low bound above high bound: empty mask
        write_window(200, 0, 0, 100, BOUND_TOP, BOUND_TOP, 0, 1'b0);
        send_pixel(8'd150, 8'd10, 8'd10, 1'b0, 1'b0);
        send_pixel(8'd200, 8'd10, 8'd10, 1'b1, 1'b0);
        send_pixel(8'd100, 8'd10, 8'd10, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd10, 8'd10, 1'b1, 1'b1);
        settle();

        // top bounds at 255, largest area floor
        write_window(0, 0, 0, 255, 255, 255, AREA_TOP, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b1);
        settle();

        // random phases: sender-light, then receiver-light, then no idling
        phase = 0;
        base  = pixels_sent;
        while (pixels_sent - base < RANDOM_ITEMS)
        begin
            progress = pixels_sent - base;
            if (progress < RANDOM_ITEMS / 3)
            begin
                send_idle = 12;
                recv_idle = 54;
            end
            else if (progress < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle = 54;
                recv_idle = 12;
            end
            else
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            random_window();
            phase_base = pixels_sent;
            if (phase == 2)
            begin
                // long result stall against a stream of tiny frames
                hold_req++;
                while (pixels_sent - phase_base < PHASE_ITEMS)
                    send_frame($urandom_range(2, 1), 1, 1'b0);
            end
            else
            begin
                while (pixels_sent - phase_base < PHASE_ITEMS)
                    send_frame($urandom_range(8, 1), $urandom_range(6, 1),
                               ($urandom_range(4) == 0));
            end
            settle();
            phase++;
        end

        if (fail_count == 0)
            $display("[hsv_threshold_blob_centroid] OK");
        else
            $display("[hsv_threshold_blob_centroid] ERROR");
        $finish;
    end

endmodule
